FILE: rtl/core/kscl_pkg.sv
// Shared widths, defaults and types for the keypad scan code lock.
package kscl_pkg;

   localparam int KEY_MATRIX_WIDTH   = 12;
   localparam int KEY_WIDTH          = 4;
   localparam int PIN_WIDTH          = 20;
   localparam int KEYPAD_ROWS        = 4;
   localparam int KEYPAD_COLS        = 3;
   localparam int HISTORY_LENGTH_DEF = 5;

   // Key released: push it into the history.
   typedef struct packed {
      logic                 push;
      logic [KEY_WIDTH-1:0] key;
   } kscl_push_type;

endpackage

FILE: rtl/core/keypad_scan_code_lock_unit.sv
// Top level of the keypad scan code lock: handshakes, press tracking, results.
// A scan tick's input transfer loads the input register; the tick then
// moves into the result register, and a result stall holds both.
// Throughput: one scan tick per cycle unless results stall; decode, history
// shift and PIN compare sit between the input and result registers.
// Reset (synchronous, active high) clears the PIN, press state, history count,
// access flag and both valid flags; history contents need no reset.
module keypad_scan_code_lock_unit
   import kscl_pkg::*;
#(
   parameter int HISTORY_LENGTH = HISTORY_LENGTH_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   // PIN register write
   input  logic                        csr_wr_en,
   input  logic [PIN_WIDTH-1:0]        csr_wr_data,
   // Scan tick input channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [KEY_MATRIX_WIDTH-1:0] req_key_matrix,
   // Result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_beep_start,
   output logic                        rsp_key_event,
   output logic [KEY_WIDTH-1:0]        rsp_event_key,
   output logic                        rsp_grant_now,
   output logic                        rsp_access_latched
);

   logic [PIN_WIDTH-1:0]        pin_ff;
   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [KEY_MATRIX_WIDTH-1:0] matrix_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;

   logic                        held_valid_ff;
   logic [KEY_WIDTH-1:0]        held_key_ff;
   logic                        beep_done_ff;
   logic                        access_ff;

   logic                        beep_ff;
   logic                        event_ff;
   logic [KEY_WIDTH-1:0]        event_key_ff;
   logic                        grant_ff;

   logic                        advance;
   logic                        accept;
   logic                        process;
   logic                        pressed;
   logic [KEY_WIDTH-1:0]        key;
   logic                        release_now;
   logic                        match;
   kscl_push_type               push_req;

   // The result register moves on when it is empty or its transfer
   // completes. The input register is then free to take a new tick in the
   // same cycle, so ticks stream at one per cycle while results flow.
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign process      = in_valid_ff && advance;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pin_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            pin_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         matrix_ff <= req_key_matrix;
      end
   end

   kscl_decode u_decode (
      .key_matrix (matrix_ff),
      .pressed    (pressed),
      .key        (key)
   );

   // A tick with no contact closed after a press ends that press: the key
   // seen on the last pressed tick is reported and enters the history.
   assign release_now   = !pressed && held_valid_ff;
   assign push_req.push = process && release_now;
   assign push_req.key  = held_key_ff;

   kscl_history #(
      .HISTORY_LENGTH (HISTORY_LENGTH)
   ) u_history (
      .clock    (clock),
      .reset    (reset),
      .push_req (push_req),
      .pin_code (pin_ff),
      .match    (match)
   );

   // Press tracking and the sticky access flag change only when a tick is
   // processed into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_key_ff   <= '0;
         beep_done_ff  <= 1'b0;
         access_ff     <= 1'b0;
      end else if (process) begin
         if (pressed) begin
            held_valid_ff <= 1'b1;
            held_key_ff   <= key;
            beep_done_ff  <= 1'b1;
         end else if (held_valid_ff) begin
            held_valid_ff <= 1'b0;
            held_key_ff   <= '0;
            beep_done_ff  <= 1'b0;
            if (match) begin
               access_ff <= 1'b1;
            end
         end
      end
   end

   // Result payload; the access flag output is the registered flag itself,
   // which already reflects the tick held in the result register.
   always_ff @(posedge clock) begin
      if (process) begin
         beep_ff      <= pressed && !beep_done_ff;
         event_ff     <= release_now;
         event_key_ff <= release_now ? held_key_ff : '0;
         grant_ff     <= release_now && match;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_beep_start     = beep_ff;
   assign rsp_key_event      = event_ff;
   assign rsp_event_key      = event_key_ff;
   assign rsp_grant_now      = grant_ff;
   assign rsp_access_latched = access_ff;

endmodule

FILE: rtl/core/kscl_decode.sv
// Priority decoder from the keypad contact matrix to one key index.
module kscl_decode
   import kscl_pkg::*;
(
   input  logic [KEY_MATRIX_WIDTH-1:0] key_matrix,
   output logic                        pressed,
   output logic [KEY_WIDTH-1:0]        key
);

   // Later assignments win: rows ascend and columns descend, so the highest
   // row and, within it, the lowest column take priority.
   always_comb begin
      pressed = 1'b0;
      key     = '0;
      for (int row = 0; row < KEYPAD_ROWS; row++) begin
         for (int col = KEYPAD_COLS - 1; col >= 0; col--) begin
            if (key_matrix[row * KEYPAD_COLS + col]) begin
               pressed = 1'b1;
               key     = KEY_WIDTH'(row * KEYPAD_COLS + col);
            end
         end
      end
   end

endmodule

FILE: rtl/core/kscl_history.sv
// Released-key history shift register and PIN comparison.
module kscl_history
   import kscl_pkg::*;
#(
   parameter int HISTORY_LENGTH = HISTORY_LENGTH_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  kscl_push_type        push_req,
   input  logic [PIN_WIDTH-1:0] pin_code,
   output logic                 match
);

   localparam int CountWidth = $clog2(HISTORY_LENGTH + 1);
   localparam int PinExtWidth = (4 * HISTORY_LENGTH > PIN_WIDTH) ?
                                4 * HISTORY_LENGTH : PIN_WIDTH;

   logic [KEY_WIDTH-1:0]   history_ff [HISTORY_LENGTH];
   logic [KEY_WIDTH-1:0]   history_in [HISTORY_LENGTH];
   logic [CountWidth-1:0]  count_ff;
   logic [CountWidth-1:0]  count_in;
   logic [PinExtWidth-1:0] pin_ext;

   // Newest key enters at the top end; once the history is full the
   // contents are the last keys in order, oldest at index zero. Before that
   // no comparison is made, so the partly filled order does not matter.
   always_comb begin
      for (int i = 0; i < HISTORY_LENGTH - 1; i++) begin
         history_in[i] = history_ff[i + 1];
      end
      history_in[HISTORY_LENGTH - 1] = push_req.key;
      if (count_ff == CountWidth'(HISTORY_LENGTH)) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + 1'b1;
      end
   end

   // PIN nibbles beyond the register width read as zero.
   assign pin_ext = PinExtWidth'(pin_code);

   always_comb begin
      match = (count_in == CountWidth'(HISTORY_LENGTH));
      for (int i = 0; i < HISTORY_LENGTH; i++) begin
         if (pin_ext[4 * (HISTORY_LENGTH - 1 - i) +: 4] != history_in[i]) begin
            match = 1'b0;
         end
      end
      if (!push_req.push) begin
         match = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (push_req.push) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_req.push) begin
         history_ff <= history_in;
      end
   end

endmodule
